// File: hdl/ptr_pkg.sv
// Package for the PI torque regulator: widths, reset values and register indexes.
package ptr_pkg;

    localparam int FRAC_BITS_DEF    = 8;
    localparam int OUTPUT_SHIFT_DEF = 8;

    localparam int TORQUE_W = 16;
    localparam int GAIN_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int PWM_W    = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TORQUE_W-1:0] SETPOINT_RST    = 16'sd640;
    localparam logic        [GAIN_W-1:0]   PROP_GAIN_RST   = 8'd5;
    localparam logic        [GAIN_W-1:0]   INTEG_GAIN_RST  = 8'd63;
    localparam logic        [LIMIT_W-1:0]  PROP_LIMIT_RST  = 16'd25;
    localparam logic        [LIMIT_W-1:0]  INTEG_LIMIT_RST = 16'd65457;

    localparam int OUT_MIN = -256;
    localparam int OUT_MAX = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_PROP_LIMIT  = 3'd3,
        REG_INTEG_LIMIT = 3'd4
    } cfg_reg_t;

endpackage

// File: hdl/pi_torque_regulator_top.sv
// PI torque regulator with anti-windup clamp, five-stage registered pipeline.
// An accepted beat passes through four register stages plus the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// The error sum is updated in stage two, an add and a clamp per valid beat as the pipeline advances.
// Reset: asynchronous, active low; config registers return to their defaults, valid flags and sum cleared.
module pi_torque_regulator_top
    import ptr_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int OUTPUT_SHIFT = OUTPUT_SHIFT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [TORQUE_W-1:0]  measured_torque,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [PWM_W-1:0]     pwm_drive
);

    localparam int ERR_W  = TORQUE_W + 1;
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int ILIM_W = LIMIT_W + FRAC_BITS;
    localparam int SUM_W  = ILIM_W + 2;
    localparam int IP_W   = SUM_W + GAIN_W + 1;
    localparam int PCW    = ((PP_W > ILIM_W + 1) ? PP_W : ILIM_W + 1) + 1;
    localparam int TOT_W  = ((PP_W > SUM_W) ? PP_W : SUM_W) + 1;
    localparam logic signed [TOT_W-1:0] BIAS =
        TOT_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(OUT_MAX);
    localparam logic signed [TOT_W-1:0] SAT_MIN = TOT_W'(OUT_MIN);

    // configuration
    logic signed [TORQUE_W-1:0] setpoint_reg;
    logic        [GAIN_W-1:0]   prop_gain_reg;
    logic        [GAIN_W-1:0]   integ_gain_reg;
    logic        [LIMIT_W-1:0]  prop_limit_reg;
    logic        [LIMIT_W-1:0]  integ_limit_reg;

    // pipeline
    logic                       advance;
    logic                       v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [PP_W-1:0]     pprod_reg, pprod_next;
    logic signed [SUM_W-1:0]    error_sum_reg, error_sum_next, sum_raw;
    logic signed [PP_W-1:0]     pterm_reg, pterm_next;
    logic signed [IP_W-1:0]     iprod_reg, iprod_next;
    logic signed [TOT_W-1:0]    total_reg, total_next;
    logic signed [PWM_W-1:0]    pwm_reg, pwm_next;

    logic signed [PCW-1:0]      pprod_x, plim_x;
    logic signed [SUM_W-1:0]    ilim_s;
    logic signed [IP_W-1:0]     ilim_p;
    logic signed [SUM_W-1:0]    iterm;
    logic signed [TOT_W-1:0]    biased, shifted;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign pwm_drive = pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg    <= SETPOINT_RST;
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            prop_limit_reg  <= PROP_LIMIT_RST;
            integ_limit_reg <= INTEG_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SETPOINT:    setpoint_reg    <= $signed(cfg_data[TORQUE_W-1:0]);
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_PROP_LIMIT:  prop_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        // stage 1: error
        err_next = ERR_W'(setpoint_reg) - ERR_W'(measured_torque);

        // stage 2: proportional product and clamped error sum
        pprod_next = PP_W'(err_reg) * $signed({1'b0, prop_gain_reg});
        ilim_s     = $signed(SUM_W'(integ_limit_reg) << FRAC_BITS);
        sum_raw    = error_sum_reg + SUM_W'(err_reg);
        if (sum_raw > ilim_s)
            error_sum_next = ilim_s;
        else if (sum_raw < -ilim_s)
            error_sum_next = -ilim_s;
        else
            error_sum_next = sum_raw;

        // stage 3: proportional clamp, integral product
        pprod_x = PCW'(pprod_reg);
        plim_x  = $signed(PCW'(prop_limit_reg) << FRAC_BITS);
        if (pprod_x > plim_x)
            pterm_next = PP_W'(plim_x);
        else if (pprod_x < -plim_x)
            pterm_next = PP_W'(-plim_x);
        else
            pterm_next = pprod_reg;
        iprod_next = IP_W'(error_sum_reg) * $signed({1'b0, integ_gain_reg});

        // stage 4: integral clamp and sum of terms
        ilim_p = $signed(IP_W'(integ_limit_reg) << FRAC_BITS);
        if (iprod_reg > ilim_p)
            iterm = SUM_W'(ilim_p);
        else if (iprod_reg < -ilim_p)
            iterm = SUM_W'(-ilim_p);
        else
            iterm = SUM_W'(iprod_reg);
        total_next = TOT_W'(pterm_reg) + TOT_W'(iterm);

        // stage 5: truncate toward zero, then floor shift; both fold into one shift
        biased  = total_reg + ((total_reg < 0) ? BIAS : '0);
        shifted = biased >>> (FRAC_BITS + OUTPUT_SHIFT);
        if (shifted > SAT_MAX)
            pwm_next = PWM_W'(SAT_MAX);
        else if (shifted < SAT_MIN)
            pwm_next = PWM_W'(SAT_MIN);
        else
            pwm_next = PWM_W'(shifted);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            error_sum_reg <= '0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v1_reg)
                error_sum_reg <= error_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err_reg   <= err_next;
            pprod_reg <= pprod_next;
            pterm_reg <= pterm_next;
            iprod_reg <= iprod_next;
            total_reg <= total_next;
            pwm_reg   <= pwm_next;
        end
    end

    // a stalled pipeline must not touch the integrator
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(error_sum_reg))
        else $error("error sum moved during stall");

    // a waiting result blocks new beats
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

    // clamped proportional term stays inside its limit
    a_pterm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (PCW'(pterm_reg) <= plim_x) && (PCW'(pterm_reg) >= -plim_x))
        else $error("proportional term outside limit");

endmodule

// File: tb/sv/tb.sv
// Testbench for the PI torque regulator: directed and random samples, drive checked beat by beat.
`timescale 1ns / 1ps

module tb;
    import ptr_pkg::*;

    localparam int NUM_REGS   = REG_INTEG_LIMIT + 1;
    localparam int LATENCY    = 5;
    localparam int STALL_LIMIT = 2000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [TORQUE_W-1:0]  measured_torque;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [PWM_W-1:0]     pwm_drive;

    // Shadow copy of the regulator registers and the error sum
    logic signed [TORQUE_W-1:0]  setpoint;
    logic        [GAIN_W-1:0]    kp;
    logic        [GAIN_W-1:0]    ki;
    logic        [LIMIT_W-1:0]   p_lim;
    logic        [LIMIT_W-1:0]   i_lim;
    logic signed [25:0]          err_acc;

    logic signed [PWM_W-1:0]     drive_expected[$];
    int                          fail_count;
    int                          in_idle_pct;
    int                          out_idle_pct;
    int                          quiet_cycles = 0;

    pi_torque_regulator_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .measured_torque (measured_torque),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pwm_drive       (pwm_drive)
    );

    always #6 clk = ~clk;

    function automatic longint clamp_symmetric(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic logic signed [PWM_W-1:0] predict_drive(logic signed [TORQUE_W-1:0] sample);
        longint err;
        longint plim;
        longint ilim;
        longint pterm;
        longint iterm;
        longint acc;
        longint whole;
        longint drive;
        err   = longint'(setpoint) - longint'(sample);
        plim  = longint'(p_lim) <<< FRAC_BITS_DEF;
        ilim  = longint'(i_lim) <<< FRAC_BITS_DEF;
        pterm = clamp_symmetric(err * longint'(kp), plim);
        acc   = clamp_symmetric(longint'(err_acc) + err, ilim);
        err_acc = acc[25:0];
        iterm = clamp_symmetric(acc * longint'(ki), ilim);
        // divide truncates toward zero, the shift floors
        whole = (pterm + iterm) / (longint'(1) <<< FRAC_BITS_DEF);
        drive = whole >>> OUTPUT_SHIFT_DEF;
        if (drive > OUT_MAX)
            drive = OUT_MAX;
        if (drive < OUT_MIN)
            drive = OUT_MIN;
        return drive[PWM_W-1:0];
    endfunction

    task automatic send_sample(logic signed [TORQUE_W-1:0] sample);
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid        <= 1'b0;
            measured_torque <= TORQUE_W'($urandom);
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        measured_torque <= sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        drive_expected.push_back(predict_drive(sample));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_SETPOINT:    setpoint = data;
            REG_PROP_GAIN:   kp = data[GAIN_W-1:0];
            REG_INTEG_GAIN:  ki = data[GAIN_W-1:0];
            REG_PROP_LIMIT:  p_lim = data;
            REG_INTEG_LIMIT: i_lim = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
    endtask

    // Gains are written with random upper bits, which the block must drop
    task automatic apply_config(logic [CFG_W-1:0] sp, logic [GAIN_W-1:0] p_gain,
                                logic [GAIN_W-1:0] i_gain, logic [LIMIT_W-1:0] pl,
                                logic [LIMIT_W-1:0] il);
        logic [CFG_W-1:0] junk;
        drain_results();
        junk = CFG_W'($urandom);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_PROP_GAIN, {junk[CFG_W-1:GAIN_W], p_gain});
        junk = CFG_W'($urandom);
        write_reg(REG_INTEG_GAIN, {junk[CFG_W-1:GAIN_W], i_gain});
        write_reg(REG_PROP_LIMIT, pl);
        write_reg(REG_INTEG_LIMIT, il);
    endtask

    function automatic logic [CFG_W-1:0] pick_field(int width, int low_max);
        logic [CFG_W-1:0] full;
        full = CFG_W'((32'd1 << width) - 32'd1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return full;
            2: return CFG_W'($urandom_range(0, low_max));
            default: return CFG_W'($urandom) & full;
        endcase
    endfunction

    function automatic logic signed [TORQUE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return setpoint + TORQUE_W'($urandom_range(0, 512)) - 16'sd256;
            5, 6, 7: return TORQUE_W'($urandom);
            8: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return ($urandom_range(0, 1) != 0) ? setpoint : 16'sd0;
        endcase
    endfunction

    task automatic test_reset_values();
        send_sample(SETPOINT_RST);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
    endtask

    task automatic test_zero_limits();
        apply_config(16'sd1000, 8'd255, 8'd255, 16'd0, 16'd0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);
    endtask

    task automatic test_saturation();
        apply_config(16'sh7fff, 8'd255, 8'd255, 16'hffff, 16'hffff);
        repeat (3)
            send_sample(16'sh8000);
        apply_config(16'sh8000, 8'd255, 8'd255, 16'hffff, 16'hffff);
        repeat (3)
            send_sample(16'sh7fff);
    endtask

    task automatic test_unused_index();
        drain_results();
        for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
        send_sample(16'sd0);
        send_sample(16'sh4000);
        send_sample(-16'sh4000);
    endtask

    task automatic test_random_traffic(int n_items, int sender_pct, int receiver_pct);
        int left;
        int chunk;
        in_idle_pct  = sender_pct;
        out_idle_pct = receiver_pct;
        left = n_items;
        while (left > 0)
        begin
            apply_config(pick_field(CFG_W, 2000), pick_field(GAIN_W, 8),
                         pick_field(GAIN_W, 8), pick_field(LIMIT_W, 300),
                         pick_field(LIMIT_W, 300));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                          CFG_W'($urandom));
            chunk = $urandom_range(40, 90);
            if (chunk > left)
                chunk = left;
            repeat (chunk)
                send_sample(pick_sample());
            left -= chunk;
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_expected.size() == 0)
            begin
                $error("pwm_drive: unexpected beat, actual %0d", pwm_drive);
                fail_count++;
            end
            else
            begin
                if (pwm_drive !== drive_expected[0])
                begin
                    $error("pwm_drive mismatch: expected %0d, actual %0d",
                           drive_expected[0], pwm_drive);
                    fail_count++;
                end
                void'(drive_expected.pop_front());
            end
        end
    end

    // Stall watchdog: any beat or register write counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        measured_torque = '0;
        out_ready       = 1'b0;
        fail_count      = 0;
        in_idle_pct     = 13;
        out_idle_pct    = 55;
        setpoint        = SETPOINT_RST;
        kp              = PROP_GAIN_RST;
        ki              = INTEG_GAIN_RST;
        p_lim           = PROP_LIMIT_RST;
        i_lim           = INTEG_LIMIT_RST;
        err_acc         = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_zero_limits();
        test_saturation();
        test_unused_index();
        test_random_traffic(320, 13, 55);
        test_random_traffic(320, 55, 13);
        test_random_traffic(310, 0, 0);

        drain_results();
        repeat (LATENCY * 4)
            @(posedge clk);
        if (drive_expected.size() != 0)
        begin
            $error("pwm_drive: %0d expected beats never arrived", drive_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
